// ----- rtl/tlvp_pkg.sv -----
// shared types, codes and helpers for the trailer tlv option parser
`default_nettype none

package tlvp_pkg;

    localparam int DEFAULT_MAX_VALUE_BYTES = 8;
    localparam int QUEUE_DEPTH             = 4;

    // walk phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SEEK = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_VAL  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_OPTION     = 2'd0;
    localparam logic [1:0] KIND_OK         = 2'd1;
    localparam logic [1:0] KIND_MALFORMED  = 2'd2;
    localparam logic [1:0] KIND_NOT_CUSTOM = 2'd3;

    localparam logic [7:0]  TYPE_MIN       = 8'd2;
    localparam logic [7:0]  TYPE_MAX       = 8'd8;
    localparam logic [7:0]  HDR_BYTES      = 8'd2;
    // fixed header bytes added to the length when the capture was truncated
    localparam logic [16:0] TRUNC_HDR      = 17'd18;
    localparam logic [15:0] TRUNC_LEN_RST  = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  pkt_byte;
        logic        start_of_packet;
        logic        end_of_packet;
        logic        is_option_protocol;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } tlvp_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  opt_type;
        logic [63:0] value;
        logic        last;
    } tlvp_result_t;

    // up to two results out of one byte, in order
    typedef struct packed {
        logic         a_valid;
        tlvp_result_t a;
        logic         b_valid;
        tlvp_result_t b;
    } tlvp_step_t;

    function automatic tlvp_result_t done_result(input logic [1:0] kind);
        tlvp_result_t r;
        r.kind     = kind;
        r.opt_type = 4'd0;
        r.value    = 64'd0;
        r.last     = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tlvp_core.sv -----
// per-byte walk state and the single-pass step logic
`default_nettype none

module tlvp_core #(
    parameter int MAX_VALUE_BYTES = tlvp_pkg::DEFAULT_MAX_VALUE_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire tlvp_pkg::tlvp_item_t item,
    input  wire logic [15:0]          trunc_len,
    output tlvp_pkg::tlvp_step_t      res
);
    import tlvp_pkg::*;

    localparam int         ACC_W   = 8 * MAX_VALUE_BYTES;
    localparam int         REM_W   = $clog2(MAX_VALUE_BYTES + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_VALUE_BYTES + 2);

    logic [15:0]      pos_reg,  pos_next;
    logic [16:0]      ts_reg,   ts_next;
    logic [2:0]       ph_reg,   ph_next;
    logic [3:0]       typ_reg,  typ_next;
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [ACC_W-1:0] acc_reg,  acc_next;
    logic             flag_reg, flag_next;

    logic type_ok;
    logic take_type;

    assign type_ok = (item.pkt_byte >= TYPE_MIN) && (item.pkt_byte <= TYPE_MAX);

    always_comb begin
        pos_next  = pos_reg;
        ts_next   = ts_reg;
        ph_next   = ph_reg;
        typ_next  = typ_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        flag_next = flag_reg;
        take_type = 1'b0;
        res       = '0;
        res.b     = done_result(KIND_MALFORMED);

        if (step) begin
            if (item.start_of_packet) begin
                flag_next = item.is_option_protocol;
                pos_next  = '0;
                typ_next  = '0;
                rem_next  = '0;
                acc_next  = '0;
                if (item.payload_length < trunc_len) begin
                    ts_next = 17'(item.payload_offset) + 17'(item.payload_length);
                end else begin
                    ts_next = 17'(item.payload_length) + TRUNC_HDR;
                end
                if (!item.is_option_protocol) begin
                    ph_next   = PH_DONE;
                    res.a_valid = 1'b1;
                    res.a       = done_result(KIND_NOT_CUSTOM);
                end else begin
                    ph_next = PH_SEEK;
                end
            end else if (ph_reg != PH_IDLE && pos_reg != 16'hFFFF) begin
                pos_next = pos_reg + 16'd1;
            end

            take_type = (ph_next == PH_TYPE) ||
                        (ph_next == PH_SEEK && {1'b0, pos_next} == ts_next);

            priority if (take_type) begin
                if (type_ok) begin
                    typ_next = item.pkt_byte[3:0];
                    ph_next  = PH_LEN;
                end else begin
                    ph_next     = PH_DONE;
                    res.a_valid = 1'b1;
                    res.a       = done_result(KIND_OK);
                end
            end else if (ph_next == PH_LEN) begin
                if (item.pkt_byte < HDR_BYTES || item.pkt_byte > MAX_LEN) begin
                    ph_next     = PH_DONE;
                    res.a_valid = 1'b1;
                    res.a       = done_result(KIND_MALFORMED);
                end else if (item.pkt_byte == HDR_BYTES) begin
                    // option with no value bytes goes out at once
                    ph_next         = PH_TYPE;
                    res.a_valid     = 1'b1;
                    res.a.kind      = KIND_OPTION;
                    res.a.opt_type  = typ_next;
                    res.a.value     = 64'd0;
                    res.a.last      = 1'b0;
                end else begin
                    rem_next = REM_W'(item.pkt_byte - HDR_BYTES);
                    acc_next = '0;
                    ph_next  = PH_VAL;
                end
            end else if (ph_next == PH_VAL) begin
                acc_next = ACC_W'({acc_next, item.pkt_byte});
                rem_next = rem_next - REM_W'(1);
                if (rem_next == '0) begin
                    ph_next        = PH_TYPE;
                    res.a_valid    = 1'b1;
                    res.a.kind     = KIND_OPTION;
                    res.a.opt_type = typ_next;
                    res.a.value    = 64'(acc_next);
                    res.a.last     = 1'b0;
                end
            end else begin
                ph_next = ph_next;
            end

            if (item.end_of_packet) begin
                // packet ended before the walk finished
                res.b_valid = (ph_next == PH_SEEK) || (ph_next == PH_TYPE) ||
                              (ph_next == PH_LEN)  || (ph_next == PH_VAL);
                ph_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            ts_reg   <= '0;
            ph_reg   <= PH_IDLE;
            typ_reg  <= '0;
            rem_reg  <= '0;
            acc_reg  <= '0;
            flag_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            ph_reg   <= ph_next;
            typ_reg  <= typ_next;
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            flag_reg <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tlvp_result_queue.sv -----
// small result queue taking up to two results a cycle and giving one when out_ready is high
`default_nettype none

module tlvp_result_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tlvp_pkg::tlvp_step_t   push,
    output logic                        room2,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output tlvp_pkg::tlvp_result_t      out_res
);
    import tlvp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tlvp_result_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [PTR_W-1:0] b_ptr;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign room2     = (cnt_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign b_ptr     = wr_ptr_reg + PTR_W'(push.a_valid);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.a_valid) + PTR_W'(push.b_valid);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push.a_valid) + CNT_W'(push.b_valid)
                      - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            entry_reg[wr_ptr_reg] <= push.a;
        end
        if (push.b_valid) begin
            entry_reg[b_ptr] <= push.b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/packet_trailer_tlv_option_parser_unit.sv -----
// top level of the packet trailer tlv option parser
`default_nettype none

// Takes one packet byte per beat and walks the type-length-value options in
// the packet trailer, giving one beat per finished option and a final status
// beat (ok, malformed or not custom). A byte is registered on acceptance and
// stepped through the walk logic once the queue has room. Its results enter
// the queue at the end of the step cycle and are offered on the m_ side in
// order after earlier ones. Unless stepping is held, one byte is taken every
// cycle. Results wait in a four-entry queue, and a byte is stepped only while
// the queue has two free entries. A packet never gives more results than it
// has bytes, so with the m_ side always ready the queue holds at most two and
// the input stalls only while the m_ side is stalled.
// trunc_len may be written only while no packet is in flight.
module packet_trailer_tlv_option_parser_unit #(
    parameter int MAX_VALUE_BYTES = tlvp_pkg::DEFAULT_MAX_VALUE_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_pkt_byte,
    input  wire logic        s_start_of_packet,
    input  wire logic        s_end_of_packet,
    input  wire logic        s_is_option_protocol,
    input  wire logic [15:0] s_payload_offset,
    input  wire logic [15:0] s_payload_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [3:0]       m_option_type,
    output logic [63:0]      m_opt_value,
    output logic             m_last_result
);
    import tlvp_pkg::*;

    logic [15:0]  trunc_len_reg;
    logic         in_valid_reg, in_valid_next;
    tlvp_item_t   in_item_reg;
    logic         room2;
    logic         step;
    logic         accept;
    tlvp_step_t   step_res;
    tlvp_result_t head;

    assign step    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || step;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            trunc_len_reg <= TRUNC_LEN_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                trunc_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg.pkt_byte           <= s_pkt_byte;
            in_item_reg.start_of_packet    <= s_start_of_packet;
            in_item_reg.end_of_packet      <= s_end_of_packet;
            in_item_reg.is_option_protocol <= s_is_option_protocol;
            in_item_reg.payload_offset     <= s_payload_offset;
            in_item_reg.payload_length     <= s_payload_length;
        end
    end

    tlvp_core #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .trunc_len (trunc_len_reg),
        .res       (step_res)
    );

    tlvp_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step_res),
        .room2     (room2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (head)
    );

    assign m_result_kind  = head.kind;
    assign m_option_type  = head.opt_type;
    assign m_opt_value    = head.value;
    assign m_last_result  = head.last;

endmodule

`default_nettype wire

// ----- rtl/tlvp_checker.sv -----
// port-level checks on the parser's result channel, bound to the top level
`default_nettype none

module tlvp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_result_kind,
    input wire logic [3:0]  m_option_type,
    input wire logic [63:0] m_opt_value,
    input wire logic        m_last_result
);
    import tlvp_pkg::*;

    // a stalled result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) &&
        $stable(m_option_type) && $stable(m_opt_value) && $stable(m_last_result))
        else $error("result beat changed while stalled");

    // status beats close the parse, option beats never do
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_result == (m_result_kind != KIND_OPTION)))
        else $error("last flag does not match result kind");

    a_opt_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_OPTION |->
        m_option_type >= 4'd2 && m_option_type <= 4'd8)
        else $error("option beat with type outside range");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_OPTION |->
        m_option_type == 4'd0 && m_opt_value == 64'd0)
        else $error("status beat carries option data");

    // nothing comes out in the cycle straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

endmodule

bind packet_trailer_tlv_option_parser_unit tlvp_checker u_tlvp_checker (.*);

`default_nettype wire
